@@ rtl/core/mnso_pkg.sv @@
// shared constants, types and constant functions for the midi note sine oscillator
`timescale 1ns / 1ps
`default_nettype none

package mnso_pkg;

    // default build values
    localparam int unsigned DEFAULT_SAMPLE_RATE      = 48000;
    localparam int unsigned DEFAULT_SINE_TABLE_DEPTH = 1024;

    // field widths
    localparam int unsigned LEVEL_W  = 15;
    localparam int unsigned SAMPLE_W = 15;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned MTYPE_W  = 4;
    localparam int unsigned STATUS_W = 8;
    localparam int unsigned OFFSET_W = 32;

    localparam int unsigned NOTE_COUNT           = 128;
    localparam int unsigned SEMITONES_PER_OCTAVE = 12;
    localparam int unsigned STEP_FRAC_SHIFT      = 27;
    localparam longint unsigned MICRO_PER_HZ     = 64'd1000000;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PHASE_W-1:0]  phase_t;
    typedef logic [NOTE_W-1:0]   note_t;
    typedef logic [OFFSET_W-1:0] offset_t;

    // item kinds carried on tuser
    localparam logic OP_MIDI = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [MTYPE_W-1:0]  MIDI1_VOICE_TYPE = 4'd2;
    localparam logic [STATUS_W-1:0] SILENCE_STATUS   = 8'h80;
    localparam level_t              LEVEL_RESET      = 15'd32767;

    // register indexes
    localparam logic REG_OUTPUT_LEVEL = 1'b0;

    // frequency of notes 60..71 in micro-hertz
    localparam logic [63:0] SEMITONE_UHZ [SEMITONES_PER_OCTAVE] = '{
        64'd261625565, 64'd277182631, 64'd293664768, 64'd311126984,
        64'd329627557, 64'd349228231, 64'd369994423, 64'd391995436,
        64'd415304698, 64'd440000000, 64'd466163762, 64'd493883301
    };

    // taylor coefficients of sin(pi/2 * u) in q30, C1..C11
    localparam logic [63:0] QUARTER_COEF [6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306,
        64'd5026995,    64'd172272,    64'd3864
    };

    localparam logic [63:0] Q30_ONE = 64'd1073741824;

    // quarter-wave sine in q30, clamped at one
    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] acc;
        logic [63:0] t;
        u2  = (u * u) >> 30;
        acc = QUARTER_COEF[5];
        for (int k = 4; k >= 0; k--) begin
            t   = (acc * u2) >> 30;
            acc = (t > QUARTER_COEF[k]) ? 64'd0 : QUARTER_COEF[k] - t;
        end
        acc = (acc * u) >> 30;
        return (acc > Q30_ONE) ? Q30_ONE : acc;
    endfunction

    // sin + 1 in q30 for an angle in turn units
    function automatic offset_t sine_offset(input logic [31:0] angle);
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] off;
        frac = {34'd0, angle[29:0]};
        mag  = angle[30] ? quarter_sine(Q30_ONE - frac) : quarter_sine(frac);
        off  = angle[31] ? Q30_ONE - mag : Q30_ONE + mag;
        return off[OFFSET_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/midi_note_sine_oscillator.sv @@
// top level of the midi note sine oscillator: stream ports, apb register, dds pipeline
`timescale 1ns / 1ps
`default_nettype none

// MIDI note sine oscillator. Input words are either MIDI messages (tuser low) or sample
// ticks (tuser high). A MIDI1 channel-voice message (type 2) loads the phase step for its
// note from a 128-entry table built for SAMPLE_RATE; status 0x80 loads zero (silence).
// Each tick gives one output word holding the same sample on left and right, equal to
// output_level * (sin + 1) / 2 taken from a SINE_TABLE_DEPTH-entry sine rom indexed by
// the 32-bit phase accumulator, which then advances by the step. One word is taken every
// clock while the output word is not stalled; a tick's sample passes through phase capture,
// sine rom read and level multiply into the output register. The whole pipeline holds
// while the output word is stalled. output_level sits at APB address 0 and resets to 32767.
module midi_note_sine_oscillator #(
    parameter int unsigned SAMPLE_RATE      = mnso_pkg::DEFAULT_SAMPLE_RATE,
    parameter int unsigned SINE_TABLE_DEPTH = mnso_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // message_type[3:0], status_byte[11:4], note_number[18:12]
    input  wire         s_tuser,   // op: 0 midi message, 1 sample tick
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // sample_left[14:0], sample_right[29:15]
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mnso_pkg::*;

    localparam int unsigned PROD_W = LEVEL_W + OFFSET_W;

    logic [MTYPE_W-1:0]  in_mtype;
    logic [STATUS_W-1:0] in_status;
    note_t               in_note;
    logic                in_accept;
    logic                pipe_en;
    logic                cfg_write;
    phase_t              note_step;
    offset_t             rom_offset;
    logic [PROD_W-1:0]   level_prod;

    level_t  level_reg,       level_next;
    phase_t  phase_acc_reg,   phase_acc_next;
    phase_t  step_reg,        step_next;
    phase_t  tick_phase_reg,  tick_phase_next;
    logic    tick_valid_reg,  tick_valid_next;
    logic    rom_valid_reg,   rom_valid_next;
    logic    out_valid_reg,   out_valid_next;
    sample_t sample_reg,      sample_next;

    // input word fields
    assign in_mtype  = s_tdata[3:0];
    assign in_status = s_tdata[11:4];
    assign in_note   = s_tdata[18:12];

    // pipeline moves when the output register is free or being taken
    assign pipe_en   = !out_valid_reg || m_tready;
    assign s_tready  = pipe_en;
    assign in_accept = s_tvalid && pipe_en;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_OUTPUT_LEVEL) ? {17'd0, level_reg} : 32'd0;

    mnso_step_table #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_step_table (
        .note (in_note),
        .step (note_step)
    );

    mnso_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .aclk   (aclk),
        .en     (pipe_en),
        .phase  (tick_phase_reg),
        .offset (rom_offset)
    );

    // level scaling of sin + 1 (q30), keep the integer part of half of it
    assign level_prod = PROD_W'(level_reg) * PROD_W'(rom_offset);

    // next state
    always_comb begin
        level_next      = level_reg;
        phase_acc_next  = phase_acc_reg;
        step_next       = step_reg;
        tick_phase_next = tick_phase_reg;
        tick_valid_next = tick_valid_reg;
        rom_valid_next  = rom_valid_reg;
        out_valid_next  = out_valid_reg;
        sample_next     = sample_reg;

        if (cfg_write && (paddr[2] == REG_OUTPUT_LEVEL)) begin
            level_next = pwdata[LEVEL_W-1:0];
        end

        // midi word sets the step, tick word captures phase and advances it
        if (in_accept) begin
            if (s_tuser == OP_TICK) begin
                tick_phase_next = phase_acc_reg;
                phase_acc_next  = phase_acc_reg + step_reg;
            end else if (in_mtype == MIDI1_VOICE_TYPE) begin
                step_next = (in_status == SILENCE_STATUS) ? '0 : note_step;
            end
        end

        if (pipe_en) begin
            tick_valid_next = in_accept && (s_tuser == OP_TICK);
            rom_valid_next  = tick_valid_reg;
            out_valid_next  = rom_valid_reg;
            if (rom_valid_reg) begin
                sample_next = level_prod[31 +: SAMPLE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= LEVEL_RESET;
            phase_acc_reg  <= '0;
            step_reg       <= '0;
            tick_valid_reg <= 1'b0;
            rom_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            level_reg      <= level_next;
            phase_acc_reg  <= phase_acc_next;
            step_reg       <= step_next;
            tick_valid_reg <= tick_valid_next;
            rom_valid_reg  <= rom_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tick_phase_reg <= tick_phase_next;
        sample_reg     <= sample_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, sample_reg, sample_reg};

endmodule

`default_nettype wire

@@ rtl/core/mnso_step_table.sv @@
// note number to phase step lookup, table built for the sample rate
`timescale 1ns / 1ps
`default_nettype none

module mnso_step_table #(
    parameter int unsigned SAMPLE_RATE = mnso_pkg::DEFAULT_SAMPLE_RATE
) (
    input  wire mnso_pkg::note_t  note,
    output mnso_pkg::phase_t      step
);
    import mnso_pkg::*;

    localparam logic [63:0] DEN = MICRO_PER_HZ * 64'(SAMPLE_RATE);

    phase_t step_rom [NOTE_COUNT];

    // step = round(f * 2^32 / fs), built per note from the octave and semitone
    for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_note
        localparam int unsigned OCT  = n / SEMITONES_PER_OCTAVE;
        localparam int unsigned SEMI = n % SEMITONES_PER_OCTAVE;
        localparam logic [63:0] NUM  = SEMITONE_UHZ[SEMI] << STEP_FRAC_SHIFT;
        localparam logic [63:0] QUO  = NUM / DEN;
        localparam logic [63:0] REM  = NUM % DEN;
        localparam logic [63:0] STEP = (QUO << OCT) + (((REM << OCT) + DEN / 2) / DEN);
        assign step_rom[n] = STEP[PHASE_W-1:0];
    end

    assign step = step_rom[note];

endmodule

`default_nettype wire

@@ rtl/core/mnso_sine_rom.sv @@
// phase to sine table index and registered sine rom read
`timescale 1ns / 1ps
`default_nettype none

module mnso_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = mnso_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  wire                    aclk,
    input  wire                    en,
    input  wire mnso_pkg::phase_t  phase,
    output mnso_pkg::offset_t      offset
);
    import mnso_pkg::*;

    localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned PROD_W  = PHASE_W + DEPTH_W;

    offset_t            sine_rom [SINE_TABLE_DEPTH];
    logic [PROD_W-1:0]  idx_prod;
    logic [IDX_W-1:0]   rom_idx;
    offset_t            offset_reg;

    // table contents: sin + 1 at the start angle of each entry
    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_entry
        localparam logic [63:0] ANG = (64'(i) << 32) / SINE_TABLE_DEPTH;
        assign sine_rom[i] = sine_offset(ANG[31:0]);
    end

    // index = floor(phase * depth / 2^32)
    assign idx_prod = PROD_W'(phase) * PROD_W'(SINE_TABLE_DEPTH);
    assign rom_idx  = idx_prod[PHASE_W +: IDX_W];

    // registered read, held while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (en) begin
            offset_reg <= sine_rom[rom_idx];
        end
    end

    assign offset = offset_reg;

endmodule

`default_nettype wire
